@@ rtl/core/sct_pkg.sv @@
package sct_pkg;

   localparam int LIST_DEPTH = 8;
   localparam int IDX_W      = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
   localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

   localparam int TIME_W     = 32;
   localparam int MEAN_W     = 12;
   localparam int SPREAD_W   = 20;
   localparam int TRACK_W    = 4;
   localparam int HOLD_W     = 16;
   localparam int OUTCOME_W  = 3;
   localparam int LIM_W      = (CNT_W > TRACK_W) ? CNT_W : TRACK_W;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TIME_W-1:0]   MAX_AGE_RESET   = 32'd35000;
   localparam logic [TRACK_W-1:0]  MAX_TRACK_RESET = 4'd5;
   localparam logic [HOLD_W-1:0]   HOLD_RESET      = 16'd333;
   localparam logic [MEAN_W-1:0]   MEAN_THR_RESET  = 12'd80;
   localparam logic [SPREAD_W-1:0] SPREAD_THR_RESET = 20'd48;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_AGE    = 3'd0,
      CSR_MAX_TRACK  = 3'd1,
      CSR_HOLD       = 3'd2,
      CSR_MEAN_THR   = 3'd3,
      CSR_SPREAD_THR = 3'd4
   } csr_index_type;

   typedef enum logic [OUTCOME_W-1:0] {
      OUT_BLANK_CONT  = 3'd0,
      OUT_BLANK_START = 3'd1,
      OUT_HELD        = 3'd2,
      OUT_MATCHED     = 3'd3,
      OUT_NEW         = 3'd4
   } outcome_type;

   typedef enum logic [1:0] {
      OP_HEAD = 2'd0,
      OP_PUSH = 2'd1,
      OP_MOVE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE   = 2'd0,
      ST_DECIDE = 2'd1,
      ST_SEARCH = 2'd2,
      ST_WRITE  = 2'd3
   } state_type;

   typedef struct packed {
      logic [TIME_W-1:0]   max_age_ms;
      logic [TRACK_W-1:0]  max_tracked;
      logic [HOLD_W-1:0]   hold_ms;
      logic [MEAN_W-1:0]   mean_threshold;
      logic [SPREAD_W-1:0] spread_threshold;
   } cfg_type;

   typedef struct packed {
      logic   load_item;
      logic   clear_idx;
      logic   step_idx;
      logic   commit;
      op_type op;
      logic   trim;
   } cmd_type;

   typedef struct packed {
      logic item_blank;
      logic head_blank;
      logic held;
      logic search_end;
      logic match;
   } status_type;

endpackage

@@ rtl/core/sct_req_if.sv @@
interface sct_req_if;
   logic                           valid;
   logic                           ready;
   logic                           is_blank;
   logic [sct_pkg::TIME_W-1:0]     frame_time_ms;
   logic [sct_pkg::MEAN_W-1:0]     bright_mean;
   logic [sct_pkg::SPREAD_W-1:0]   bright_spread;

   modport source (output valid, is_blank, frame_time_ms, bright_mean, bright_spread,
                   input ready);
   modport sink (input valid, is_blank, frame_time_ms, bright_mean, bright_spread,
                 output ready);
endinterface

@@ rtl/core/sct_rsp_if.sv @@
interface sct_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            scene_start;
   logic [sct_pkg::OUTCOME_W-1:0]   outcome;

   modport source (output valid, scene_start, outcome, input ready);
   modport sink (input valid, scene_start, outcome, output ready);
endinterface

@@ rtl/core/sct_csr.sv @@
module sct_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_write_enable,
   input  logic [sct_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [sct_pkg::CSR_DATA_W-1:0]    csr_write_data,
   output sct_pkg::cfg_type                  cfg
);

   sct_pkg::cfg_type cfg_ff;
   sct_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (sct_pkg::csr_index_type'(csr_index))
            sct_pkg::CSR_MAX_AGE: begin
               cfg_in.max_age_ms = csr_write_data[sct_pkg::TIME_W-1:0];
            end
            sct_pkg::CSR_MAX_TRACK: begin
               cfg_in.max_tracked = csr_write_data[sct_pkg::TRACK_W-1:0];
            end
            sct_pkg::CSR_HOLD: begin
               cfg_in.hold_ms = csr_write_data[sct_pkg::HOLD_W-1:0];
            end
            sct_pkg::CSR_MEAN_THR: begin
               cfg_in.mean_threshold = csr_write_data[sct_pkg::MEAN_W-1:0];
            end
            sct_pkg::CSR_SPREAD_THR: begin
               cfg_in.spread_threshold = csr_write_data[sct_pkg::SPREAD_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_age_ms       <= sct_pkg::MAX_AGE_RESET;
         cfg_ff.max_tracked      <= sct_pkg::MAX_TRACK_RESET;
         cfg_ff.hold_ms          <= sct_pkg::HOLD_RESET;
         cfg_ff.mean_threshold   <= sct_pkg::MEAN_THR_RESET;
         cfg_ff.spread_threshold <= sct_pkg::SPREAD_THR_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/sct_dp.sv @@
module sct_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  sct_pkg::cfg_type                cfg,
   input  logic                            req_is_blank,
   input  logic [sct_pkg::TIME_W-1:0]      req_frame_time_ms,
   input  logic [sct_pkg::MEAN_W-1:0]      req_bright_mean,
   input  logic [sct_pkg::SPREAD_W-1:0]    req_bright_spread,
   input  sct_pkg::cmd_type                cmd,
   output sct_pkg::status_type             status
);

   localparam int D = sct_pkg::LIST_DEPTH;
   localparam int CW = sct_pkg::CNT_W;

   logic                          item_blank_ff;
   logic [sct_pkg::TIME_W-1:0]    item_time_ff;
   logic [sct_pkg::MEAN_W-1:0]    item_mean_ff;
   logic [sct_pkg::SPREAD_W-1:0]  item_spread_ff;

   logic                          blank_ff  [D];
   logic [sct_pkg::TIME_W-1:0]    time_ff   [D];
   logic [sct_pkg::MEAN_W-1:0]    mean_ff   [D];
   logic [sct_pkg::SPREAD_W-1:0]  spread_ff [D];

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;

   logic [sct_pkg::IDX_W-1:0]     sel;
   logic [sct_pkg::TIME_W-1:0]    head_gap;
   logic [sct_pkg::TIME_W-1:0]    age;
   logic [sct_pkg::MEAN_W-1:0]    mean_diff;
   logic [sct_pkg::SPREAD_W-1:0]  spread_diff;
   logic [CW-1:0]                 push_cnt;
   logic [CW-1:0]                 pushed;
   logic [CW-1:0]                 boundary;
   logic [sct_pkg::TRACK_W-1:0]   limit_m1;
   logic [sct_pkg::LIM_W-1:0]     limit_ext;

   // Status for the controller: head checks use fixed places, the walk reads one entry.
   always_comb begin
      sel      = idx_ff[sct_pkg::IDX_W-1:0];
      head_gap = time_ff[0] - time_ff[1];
      age      = item_time_ff - time_ff[sel];
      mean_diff = (item_mean_ff >= mean_ff[sel]) ? item_mean_ff - mean_ff[sel]
                                                 : mean_ff[sel] - item_mean_ff;
      spread_diff = (item_spread_ff >= spread_ff[sel]) ? item_spread_ff - spread_ff[sel]
                                                       : spread_ff[sel] - item_spread_ff;

      status.item_blank = item_blank_ff;
      status.head_blank = (count_ff != '0) && blank_ff[0];
      status.held       = (count_ff > CW'(1)) && !blank_ff[0] &&
                          (head_gap < sct_pkg::TIME_W'(cfg.hold_ms));
      status.search_end = (idx_ff == count_ff) || (age > cfg.max_age_ms);
      status.match      = (mean_diff <= cfg.mean_threshold) &&
                          (spread_diff <= cfg.spread_threshold);
   end

   // A push into a full list loses the oldest entry first.
   always_comb begin
      push_cnt  = (count_ff >= CW'(D)) ? CW'(D - 1) : count_ff;
      pushed    = push_cnt + CW'(1);
      limit_m1  = (cfg.max_tracked < sct_pkg::TRACK_W'(2)) ? sct_pkg::TRACK_W'(1)
                                                           : cfg.max_tracked - sct_pkg::TRACK_W'(1);
      limit_ext = sct_pkg::LIM_W'(limit_m1);

      case (cmd.op)
         sct_pkg::OP_HEAD: boundary = '0;
         sct_pkg::OP_PUSH: boundary = push_cnt;
         sct_pkg::OP_MOVE: boundary = idx_ff;
         default:          boundary = '0;
      endcase

      count_in = count_ff;
      if (cmd.commit && (cmd.op == sct_pkg::OP_PUSH)) begin
         count_in = pushed;
         if (cmd.trim && (sct_pkg::LIM_W'(pushed) > limit_ext)) begin
            count_in = CW'(limit_ext);
         end
      end

      idx_in = idx_ff;
      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if (cmd.step_idx) begin
         idx_in = idx_ff + CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         idx_ff   <= '0;
      end else begin
         count_ff <= count_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_blank_ff  <= req_is_blank;
         item_time_ff   <= req_frame_time_ms;
         item_mean_ff   <= req_bright_mean;
         item_spread_ff <= req_bright_spread;
      end
   end

   // Entries from one up to the boundary move one place back; the item lands at the head.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         for (int k = 1; k < D; k++) begin
            if (CW'(k) <= boundary) begin
               blank_ff[k]  <= blank_ff[k-1];
               time_ff[k]   <= time_ff[k-1];
               mean_ff[k]   <= mean_ff[k-1];
               spread_ff[k] <= spread_ff[k-1];
            end
         end
         blank_ff[0]  <= item_blank_ff;
         time_ff[0]   <= item_time_ff;
         mean_ff[0]   <= item_mean_ff;
         spread_ff[0] <= item_spread_ff;
      end
   end

endmodule

@@ rtl/core/sct_ctrl.sv @@
module sct_ctrl (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_scene_start,
   output logic [sct_pkg::OUTCOME_W-1:0]    rsp_outcome,
   input  sct_pkg::status_type              status,
   output sct_pkg::cmd_type                 cmd
);

   sct_pkg::state_type   state_ff, state_in;
   sct_pkg::op_type      op_ff, op_in;
   logic                 trim_ff, trim_in;
   sct_pkg::outcome_type result_ff, result_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   sct_pkg::outcome_type outcome_ff, outcome_in;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      trim_in      = trim_ff;
      result_in    = result_ff;
      outcome_in   = outcome_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd.load_item = 1'b0;
      cmd.clear_idx = 1'b0;
      cmd.step_idx  = 1'b0;
      cmd.commit    = 1'b0;
      cmd.op        = op_ff;
      cmd.trim      = trim_ff;

      case (state_ff)
         sct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               cmd.clear_idx = 1'b1;
               state_in      = sct_pkg::ST_DECIDE;
            end
         end
         sct_pkg::ST_DECIDE: begin
            trim_in = 1'b0;
            if (status.item_blank) begin
               state_in = sct_pkg::ST_WRITE;
               if (status.head_blank) begin
                  op_in     = sct_pkg::OP_HEAD;
                  result_in = sct_pkg::OUT_BLANK_CONT;
               end else begin
                  op_in     = sct_pkg::OP_PUSH;
                  result_in = sct_pkg::OUT_BLANK_START;
               end
            end else if (status.held) begin
               op_in     = sct_pkg::OP_HEAD;
               result_in = sct_pkg::OUT_HELD;
               state_in  = sct_pkg::ST_WRITE;
            end else begin
               state_in = sct_pkg::ST_SEARCH;
            end
         end
         sct_pkg::ST_SEARCH: begin
            // End of list or an entry past the age limit ends the walk unmatched.
            if (status.search_end) begin
               op_in     = sct_pkg::OP_PUSH;
               trim_in   = 1'b1;
               result_in = sct_pkg::OUT_NEW;
               state_in  = sct_pkg::ST_WRITE;
            end else if (status.match) begin
               op_in     = sct_pkg::OP_MOVE;
               result_in = sct_pkg::OUT_MATCHED;
               state_in  = sct_pkg::ST_WRITE;
            end else begin
               cmd.step_idx = 1'b1;
            end
         end
         sct_pkg::ST_WRITE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit   = 1'b1;
               rsp_valid_in = 1'b1;
               outcome_in   = result_ff;
               state_in     = sct_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sct_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sct_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      trim_ff    <= trim_in;
      result_ff  <= result_in;
      outcome_ff <= outcome_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_outcome     = outcome_ff;
   assign rsp_scene_start = (outcome_ff == sct_pkg::OUT_BLANK_START) ||
                            (outcome_ff == sct_pkg::OUT_NEW);

endmodule

@@ rtl/core/scene_change_tracker.sv @@
// Scene change tracker: every frame transfer on req_ch (blank flag, timestamp in ms, brightness
// mean and variance with 4 fraction bits) yields exactly one transfer on rsp_ch carrying the
// outcome and a scene start flag, in order. The block keeps up to eight recent scenes newest
// first in registers and walks them with a single comparator, one entry per cycle. Blank or
// held items go from decide to write, others search in between; the write waits while the
// last result is not taken. One item is in work at a time; the finished result sits in an
// output register, so the next frame is taken while it waits. Registers on the csr_ port must
// be written by the user only while no frame is in work; the block itself does not enforce it.
module scene_change_tracker (
   input  logic                             clock,
   input  logic                             reset,
   sct_req_if.sink                          req_ch,
   sct_rsp_if.source                        rsp_ch,
   input  logic                             csr_write_enable,
   input  logic [sct_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [sct_pkg::CSR_DATA_W-1:0]   csr_write_data
);

   sct_pkg::cfg_type    cfg;
   sct_pkg::cmd_type    cmd;
   sct_pkg::status_type status;

   logic                            req_ready;
   logic                            rsp_valid;
   logic                            rsp_scene_start;
   logic [sct_pkg::OUTCOME_W-1:0]   rsp_outcome;

   sct_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   sct_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_is_blank      (req_ch.is_blank),
      .req_frame_time_ms (req_ch.frame_time_ms),
      .req_bright_mean   (req_ch.bright_mean),
      .req_bright_spread (req_ch.bright_spread),
      .cmd               (cmd),
      .status            (status)
   );

   sct_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ready),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_scene_start (rsp_scene_start),
      .rsp_outcome     (rsp_outcome),
      .status          (status),
      .cmd             (cmd)
   );

   assign req_ch.ready       = req_ready;
   assign rsp_ch.valid       = rsp_valid;
   assign rsp_ch.scene_start = rsp_scene_start;
   assign rsp_ch.outcome     = rsp_outcome;

endmodule

@@ rtl/core/sct_checker.sv @@
module sct_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_scene_start,
   input logic [sct_pkg::OUTCOME_W-1:0]    rsp_outcome
);

   // After reset the block is empty and waits for a frame.
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_valid && req_ready))
      else $error("block not idle after reset");

   // Only one frame is in work: a transfer closes the input for the next cycle.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("input open right after a transfer");

   // The scene start flag follows the outcome.
   a_start_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_scene_start ==
         ((rsp_outcome == sct_pkg::OUT_BLANK_START) || (rsp_outcome == sct_pkg::OUT_NEW))))
      else $error("scene start flag disagrees with outcome");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_outcome)))
      else $error("stalled result changed");

endmodule

bind scene_change_tracker sct_checker u_sct_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_scene_start (rsp_ch.scene_start),
   .rsp_outcome     (rsp_ch.outcome)
);

@@ tb/tb_scene_change_tracker.sv @@
module tb_scene_change_tracker;
   timeunit 1ns;
   timeprecision 1ps;

   import sct_pkg::*;

   localparam int PALETTE_SIZE   = 6;
   localparam int PHASE_ITEMS    = 220;
   localparam int STALL_CYCLES   = 500;
   localparam int SETTLE_CYCLES  = 16;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int MEAN_MAX       = (1 << MEAN_W) - 1;
   localparam int SPREAD_MAX     = (1 << SPREAD_W) - 1;

   typedef struct packed {
      logic                is_blank;
      logic [TIME_W-1:0]   frame_time_ms;
      logic [MEAN_W-1:0]   bright_mean;
      logic [SPREAD_W-1:0] bright_spread;
   } frame_type;

   typedef struct packed {
      logic        scene_start;
      outcome_type outcome;
   } verdict_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_write_enable;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_write_data;

   sct_req_if req_if();
   sct_rsp_if rsp_if();

   scene_change_tracker u_top (
      .clock            (clock),
      .reset            (reset),
      .req_ch           (req_if),
      .rsp_ch           (rsp_if),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Shadow of the scene list, updated at each accepted frame, and of the registers.
   cfg_type             active_cfg;
   int                  scene_count;
   logic                scene_blank  [LIST_DEPTH];
   logic [TIME_W-1:0]   scene_time   [LIST_DEPTH];
   logic [MEAN_W-1:0]   scene_mean   [LIST_DEPTH];
   logic [SPREAD_W-1:0] scene_spread [LIST_DEPTH];

   verdict_type         pending_verdicts [$];
   int                  failures;
   bit                  quiet_mode;
   int                  stall_request;

   logic [TIME_W-1:0]   frame_clock;
   int                  scene_pick;
   int                  palette_mean   [PALETTE_SIZE];
   int                  palette_spread [PALETTE_SIZE];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void store_scene(input int k, input frame_type f);
      scene_blank[k]  = f.is_blank;
      scene_time[k]   = f.frame_time_ms;
      scene_mean[k]   = f.bright_mean;
      scene_spread[k] = f.bright_spread;
   endfunction

   // Moves entries 0 .. last-1 one place towards the tail; entry last is overwritten.
   function automatic void shift_scenes(input int last);
      for (int k = last; k > 0; k--) begin
         scene_blank[k]  = scene_blank[k-1];
         scene_time[k]   = scene_time[k-1];
         scene_mean[k]   = scene_mean[k-1];
         scene_spread[k] = scene_spread[k-1];
      end
   endfunction

   function automatic void push_scene(input frame_type f);
      if (scene_count >= LIST_DEPTH) scene_count = LIST_DEPTH - 1;
      shift_scenes(scene_count);
      store_scene(0, f);
      scene_count++;
   endfunction

   function automatic verdict_type classify_frame(input frame_type f);
      verdict_type       v;
      logic [TIME_W-1:0] head_span;
      logic [TIME_W-1:0] age;
      logic [MEAN_W-1:0] mean_gap;
      logic [SPREAD_W-1:0] spread_gap;
      int                trim_at;
      bit                found;
      found     = 1'b0;
      head_span = scene_time[0] - scene_time[1];
      if (f.is_blank) begin
         if (scene_count > 0 && scene_blank[0]) begin
            store_scene(0, f);
            v.outcome = OUT_BLANK_CONT;
         end else begin
            push_scene(f);
            v.outcome = OUT_BLANK_START;
         end
      end else if (scene_count > 1 && !scene_blank[0] && head_span < active_cfg.hold_ms) begin
         store_scene(0, f);
         v.outcome = OUT_HELD;
      end else begin
         for (int i = 0; i < scene_count && !found; i++) begin
            // Ages wrap, so a timestamp that runs backwards looks very old.
            age = f.frame_time_ms - scene_time[i];
            if (age > active_cfg.max_age_ms) break;
            mean_gap   = (scene_mean[i] > f.bright_mean) ? scene_mean[i] - f.bright_mean
                                                         : f.bright_mean - scene_mean[i];
            spread_gap = (scene_spread[i] > f.bright_spread) ? scene_spread[i] - f.bright_spread
                                                             : f.bright_spread - scene_spread[i];
            if (mean_gap <= active_cfg.mean_threshold &&
                spread_gap <= active_cfg.spread_threshold) begin
               shift_scenes(i);
               store_scene(0, f);
               found = 1'b1;
            end
         end
         if (found) begin
            v.outcome = OUT_MATCHED;
         end else begin
            push_scene(f);
            trim_at = (active_cfg.max_tracked < 2) ? 2 : int'(active_cfg.max_tracked);
            while (scene_count >= trim_at) scene_count--;
            v.outcome = OUT_NEW;
         end
      end
      v.scene_start = (v.outcome == OUT_BLANK_START) || (v.outcome == OUT_NEW);
      return v;
   endfunction

   function automatic frame_type mk_frame(input logic b, input logic [TIME_W-1:0] t,
                                          input logic [MEAN_W-1:0] m,
                                          input logic [SPREAD_W-1:0] s);
      frame_type f;
      f.is_blank      = b;
      f.frame_time_ms = t;
      f.bright_mean   = m;
      f.bright_spread = s;
      return f;
   endfunction

   // Mostly plausible video: steady frame times, scenes that persist and recur, short
   // blank runs. A small share is pure noise with arbitrary timestamps.
   function automatic frame_type next_frame();
      frame_type f;
      int        roll;
      int        step_roll;
      int        step;
      int        level;
      int        spread_level;
      roll       = $urandom_range(99);
      f.is_blank = 1'b0;
      if (roll < 6) begin
         f.is_blank      = 1'($urandom_range(1));
         f.frame_time_ms = $urandom;
         f.bright_mean   = MEAN_W'($urandom);
         f.bright_spread = SPREAD_W'($urandom);
      end else begin
         step_roll = $urandom_range(99);
         if (step_roll < 5) step = 0;
         else if (step_roll < 85) step = $urandom_range(20, 50);
         else if (step_roll < 97) step = $urandom_range(300, 40000);
         else step = $urandom_range(40000, 200000);
         frame_clock = frame_clock + step;
         if ($urandom_range(99) < 10) scene_pick = $urandom_range(PALETTE_SIZE - 1);
         f.frame_time_ms = frame_clock;
         if (roll < 18) begin
            f.is_blank   = 1'b1;
            level        = $urandom_range(0, 200);
            spread_level = $urandom_range(0, 400);
         end else begin
            level        = palette_mean[scene_pick];
            spread_level = palette_spread[scene_pick];
            if ($urandom_range(99) >= 30) begin
               level        += int'($urandom_range(0, 240)) - 120;
               spread_level += int'($urandom_range(0, 160)) - 80;
            end
         end
         f.bright_mean   = MEAN_W'((level < 0) ? 0 : (level > MEAN_MAX) ? MEAN_MAX : level);
         f.bright_spread = SPREAD_W'((spread_level < 0) ? 0 :
                           (spread_level > SPREAD_MAX) ? SPREAD_MAX : spread_level);
      end
      return f;
   endfunction

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.max_age_ms       = $urandom_range(1000, 60000);
      c.max_tracked      = TRACK_W'($urandom_range(2, 8));
      c.hold_ms          = HOLD_W'($urandom_range(0, 700));
      c.mean_threshold   = MEAN_W'($urandom_range(0, 160));
      c.spread_threshold = SPREAD_W'($urandom_range(0, 120));
      return c;
   endfunction

   // Returns at the edge where the frame is taken, with valid still high; the caller
   // either offers the next frame or lowers valid in the same step.
   task automatic send_frame(input frame_type f);
      while (!quiet_mode && $urandom_range(99) < 25) begin
         req_if.valid         <= 1'b0;
         req_if.is_blank      <= 1'($urandom);
         req_if.frame_time_ms <= $urandom;
         req_if.bright_mean   <= MEAN_W'($urandom);
         req_if.bright_spread <= SPREAD_W'($urandom);
         @(posedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.is_blank      <= f.is_blank;
      req_if.frame_time_ms <= f.frame_time_ms;
      req_if.bright_mean   <= f.bright_mean;
      req_if.bright_spread <= f.bright_spread;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      pending_verdicts.push_back(classify_frame(f));
   endtask

   task automatic settle_block();
      req_if.valid <= 1'b0;
      while (pending_verdicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_regs(input cfg_type c);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MAX_AGE;    csr_write_data <= CSR_DATA_W'(c.max_age_ms);
      @(posedge clock);
      csr_index <= CSR_MAX_TRACK;  csr_write_data <= CSR_DATA_W'(c.max_tracked);
      @(posedge clock);
      csr_index <= CSR_HOLD;       csr_write_data <= CSR_DATA_W'(c.hold_ms);
      @(posedge clock);
      csr_index <= CSR_MEAN_THR;   csr_write_data <= CSR_DATA_W'(c.mean_threshold);
      @(posedge clock);
      csr_index <= CSR_SPREAD_THR; csr_write_data <= CSR_DATA_W'(c.spread_threshold);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_cfg = c;
   endtask

   // Runs on the reset settings: every outcome, field extremes, the age limit, exact
   // threshold boundaries, wrapping timestamps and a blank entry found by the search.
   task automatic test_directed();
      send_frame(mk_frame(1'b0, 32'd0, 12'd0, 20'd0));
      send_frame(mk_frame(1'b0, 32'd10, 12'hFFF, 20'hFFFFF));
      send_frame(mk_frame(1'b0, 32'd20, 12'hFFF, 20'hFFFFF));
      send_frame(mk_frame(1'b1, 32'd30, 12'h7FF, 20'h00000));
      send_frame(mk_frame(1'b1, 32'd40, 12'h800, 20'h80000));
      send_frame(mk_frame(1'b0, 32'd1000, 12'd5, 20'd3));
      send_frame(mk_frame(1'b0, 32'd40000, 12'd85, 20'd51));
      send_frame(mk_frame(1'b0, 32'd40100, 12'd165, 20'd99));
      send_frame(mk_frame(1'b0, 32'd40200, 12'd246, 20'd99));
      send_frame(mk_frame(1'b0, 32'hFFFF_FFFF, 12'd246, 20'd99));
      send_frame(mk_frame(1'b0, 32'd5, 12'd0, 20'hFFFFF));
      send_frame(mk_frame(1'b1, 32'h8000_0000, 12'hFFF, 20'hFFFFF));
      send_frame(mk_frame(1'b1, 32'd0, 12'hFFF, 20'hFFFFF));
      send_frame(mk_frame(1'b0, 32'd100, 12'hFFF, 20'hFFFFF));
   endtask

   // No trimming and exact matching only, so the store overflows, its deepest entry is found
   // and the oldest one, dropped at the overflow, is not found again.
   task automatic test_store_full();
      settle_block();
      program_regs({32'hFFFF_FFFF, 4'd15, 16'd0, 12'd0, 20'd0});
      for (int k = 0; k < 9; k++) begin
         send_frame(mk_frame(1'b0, 32'(k * 100), 12'(k * 100 + 1), 20'(k * 7)));
      end
      send_frame(mk_frame(1'b0, 32'd1000, 12'd101, 20'd7));
      send_frame(mk_frame(1'b0, 32'd1100, 12'd1, 20'd0));
   endtask

   task automatic test_random_phase(input int phase);
      cfg_type c;
      settle_block();
      quiet_mode = (phase == 0);
      case (phase)
         0:       c = {MAX_AGE_RESET, MAX_TRACK_RESET, HOLD_RESET, MEAN_THR_RESET,
                       SPREAD_THR_RESET};
         1:       c = {32'd0, 4'd1, 16'hFFFF, 12'hFFF, 20'hFFFFF};
         2:       c = {32'hFFFF_FFFF, 4'd8, 16'd0, 12'd0, 20'd0};
         3:       c = {32'hFFFF_FFFF, 4'd15, 16'd40, 12'd120, 20'd80};
         4:       c = {32'd35000, 4'd0, 16'd333, 12'd80, 20'd48};
         5:       c = {32'd2000, 4'd9, 16'd100, 12'd255, 20'd255};
         default: c = random_cfg();
      endcase
      program_regs(c);
      for (int p = 0; p < PALETTE_SIZE; p++) begin
         palette_mean[p]   = $urandom_range(0, MEAN_MAX);
         palette_spread[p] = $urandom_range(0, SPREAD_MAX);
      end
      // Two neighbouring scenes, so that near misses on the thresholds occur.
      palette_mean[PALETTE_SIZE-1]   = palette_mean[PALETTE_SIZE-2] / 2 + 40;
      palette_mean[PALETTE_SIZE-2]   = palette_mean[PALETTE_SIZE-2] / 2;
      palette_spread[PALETTE_SIZE-1] = palette_spread[PALETTE_SIZE-2];
      frame_clock = $urandom;
      scene_pick  = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) send_frame(next_frame());
   endtask

   // The receiver holds off for a long stretch while frames keep being offered.
   task automatic test_backpressure();
      settle_block();
      quiet_mode = 1'b0;
      program_regs(random_cfg());
      for (int n = 0; n < 20; n++) send_frame(next_frame());
      stall_request = STALL_CYCLES;
      for (int n = 0; n < 60; n++) send_frame(next_frame());
   endtask

   initial begin : result_checker
      verdict_type want;
      int          stall_left;
      stall_left   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
            if (pending_verdicts.size() == 0) begin
               $error("result transfer with no frame waiting: scene_start=%0d outcome=%0d",
                      rsp_if.scene_start, rsp_if.outcome);
               failures++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_if.scene_start !== want.scene_start) begin
                  $error("scene_start: expected %0d, actual %0d", want.scene_start,
                         rsp_if.scene_start);
                  failures++;
               end
               if (rsp_if.outcome !== want.outcome) begin
                  $error("outcome: expected %0d, actual %0d", want.outcome, rsp_if.outcome);
                  failures++;
               end
            end
         end
         if (stall_request > 0) begin
            stall_left    = stall_request;
            stall_request = 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= quiet_mode || ($urandom_range(99) >= 25);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) quiet_cycles = 0;
         else quiet_cycles++;
      end
      $display("scene_change_tracker: mismatch");
      $finish;
   end

   initial begin
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.is_blank      = 1'b0;
      req_if.frame_time_ms = '0;
      req_if.bright_mean   = '0;
      req_if.bright_spread = '0;
      csr_write_enable     = 1'b0;
      csr_index            = '0;
      csr_write_data       = '0;
      active_cfg = {MAX_AGE_RESET, MAX_TRACK_RESET, HOLD_RESET, MEAN_THR_RESET,
                    SPREAD_THR_RESET};
      scene_count   = 0;
      failures      = 0;
      quiet_mode    = 1'b0;
      stall_request = 0;
      frame_clock   = '0;
      scene_pick    = 0;
      for (int k = 0; k < LIST_DEPTH; k++) begin
         scene_blank[k]  = 1'b0;
         scene_time[k]   = '0;
         scene_mean[k]   = '0;
         scene_spread[k] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_store_full();
      for (int phase = 0; phase < 4; phase++) test_random_phase(phase);
      test_backpressure();
      for (int phase = 4; phase < 7; phase++) test_random_phase(phase);
      settle_block();
      if (failures == 0) $display("scene_change_tracker: match");
      else $display("scene_change_tracker: mismatch");
      $finish;
   end

endmodule

@@ scene_change_tracker.f @@
rtl/core/sct_pkg.sv
rtl/core/sct_req_if.sv
rtl/core/sct_rsp_if.sv
rtl/core/sct_csr.sv
rtl/core/sct_dp.sv
rtl/core/sct_ctrl.sv
rtl/core/scene_change_tracker.sv
rtl/core/sct_checker.sv
tb/tb_scene_change_tracker.sv
